FILE: design/assert_macros.svh
// Assertion macros for the design files; encoded_word_unescaper includes them.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: design/euw_pkg.sv
// Types, character codes and helpers for the encoded-word unescaper.
// No dependencies; used by euw_decode and encoded_word_unescaper.
package euw_pkg;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_QM = 8'h3F;

	typedef enum logic [2:0] {
		MODE_PASS    = 3'd0,
		MODE_EQ      = 3'd1,
		MODE_CHARSET = 3'd2,
		MODE_ENC     = 3'd3,
		MODE_TEXT    = 3'd4,
		MODE_HEXHI   = 3'd5,
		MODE_HEXLO   = 3'd6,
		MODE_CLOSE   = 3'd7
	} mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_mark;
		logic       last_of_run;
	} result_t;

	// Up to two results per item; count says how many are meaningful.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} dec_out_t;

	// Hex digit value; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else if (c inside {[8'h61:8'h66]}) begin
			v = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			v = 4'(c - 8'h37);
		end
		return v;
	endfunction

	function automatic result_t make_result(input logic [7:0] b, input logic bv,
			input logic em);
		result_t r;
		r.out_byte    = b;
		r.byte_valid  = bv;
		r.end_mark    = em;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

FILE: design/euw_decode.sv
// Parser state machine: turns one registered item into up to two results.
// Depends on euw_pkg.
module euw_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              op,
	input  logic [7:0]        byte_value,
	output euw_pkg::dec_out_t dec
);

	euw_pkg::mode_t mode_q, mode_d;
	logic [3:0]     nib_q, nib_d;
	logic [3:0]     digit;
	euw_pkg::result_t flush_r, end_r;

	assign digit = euw_pkg::hex_value(byte_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= euw_pkg::MODE_PASS;
			nib_q  <= 4'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			nib_q  <= nib_d;
		end
	end

	always_comb begin
		dec        = '0;
		mode_d     = mode_q;
		nib_d      = nib_q;
		flush_r    = '0;
		end_r      = euw_pkg::make_result(8'd0, 1'b0, 1'b1);
		if (op) begin
			// end of stream: flush a pending '=' or hex byte, then the end mark
			case (mode_q)
				euw_pkg::MODE_EQ: begin
					flush_r   = euw_pkg::make_result(euw_pkg::CH_EQ, 1'b1, 1'b0);
					dec.count = 2'd2;
				end
				euw_pkg::MODE_HEXHI: begin
					flush_r   = euw_pkg::make_result(8'd0, 1'b1, 1'b0);
					dec.count = 2'd2;
				end
				euw_pkg::MODE_HEXLO: begin
					flush_r   = euw_pkg::make_result({nib_q, 4'd0}, 1'b1, 1'b0);
					dec.count = 2'd2;
				end
				default: begin
					dec.count = 2'd1;
				end
			endcase
			if (dec.count == 2'd2) begin
				dec.first  = flush_r;
				dec.second = end_r;
			end else begin
				dec.first  = end_r;
			end
			mode_d = euw_pkg::MODE_PASS;
			nib_d  = 4'd0;
		end else begin
			case (mode_q)
				euw_pkg::MODE_EQ: begin
					if (byte_value == euw_pkg::CH_QM) begin
						mode_d = euw_pkg::MODE_CHARSET;
					end else begin
						dec.first  = euw_pkg::make_result(euw_pkg::CH_EQ, 1'b1, 1'b0);
						dec.second = euw_pkg::make_result(byte_value, 1'b1, 1'b0);
						dec.count  = 2'd2;
						mode_d     = euw_pkg::MODE_PASS;
					end
				end
				euw_pkg::MODE_CHARSET: begin
					if (byte_value == euw_pkg::CH_QM) begin
						mode_d = euw_pkg::MODE_ENC;
					end
				end
				euw_pkg::MODE_ENC: begin
					if (byte_value == euw_pkg::CH_QM) begin
						mode_d = euw_pkg::MODE_TEXT;
					end
				end
				euw_pkg::MODE_TEXT: begin
					if (byte_value == euw_pkg::CH_QM) begin
						mode_d = euw_pkg::MODE_CLOSE;
					end else if (byte_value == euw_pkg::CH_EQ) begin
						mode_d = euw_pkg::MODE_HEXHI;
					end else begin
						dec.first = euw_pkg::make_result(byte_value, 1'b1, 1'b0);
						dec.count = 2'd1;
					end
				end
				euw_pkg::MODE_HEXHI: begin
					nib_d  = digit;
					mode_d = euw_pkg::MODE_HEXLO;
				end
				euw_pkg::MODE_HEXLO: begin
					dec.first = euw_pkg::make_result({nib_q, digit}, 1'b1, 1'b0);
					dec.count = 2'd1;
					nib_d     = 4'd0;
					mode_d    = euw_pkg::MODE_TEXT;
				end
				euw_pkg::MODE_CLOSE: begin
					// closing '=' is swallowed, anything else falls out as plain data
					if (byte_value != euw_pkg::CH_EQ) begin
						dec.first = euw_pkg::make_result(byte_value, 1'b1, 1'b0);
						dec.count = 2'd1;
					end
					mode_d = euw_pkg::MODE_PASS;
				end
				default: begin
					if (byte_value == euw_pkg::CH_EQ) begin
						mode_d = euw_pkg::MODE_EQ;
					end else begin
						dec.first = euw_pkg::make_result(byte_value, 1'b1, 1'b0);
						dec.count = 2'd1;
					end
				end
			endcase
		end
		if (dec.count == 2'd2) begin
			dec.second.last_of_run = 1'b1;
		end else if (dec.count == 2'd1) begin
			dec.first.last_of_run = 1'b1;
		end
	end

endmodule

FILE: design/encoded_word_unescaper.sv
// Encoded-word unescaper: input register, parser, result queue of DEPTH entries.
// An accepted item is registered in the input stage, decoded by the parser and written to the queue.
// Throughput: one item per cycle while item_stall is low; the queue drains one result per cycle
// while result_stall is low, so items giving two results are absorbed by the queue and back-pressure via item_stall.
// Reset clears the parser state, the input stage valid and the queue fill.
// Depends on euw_pkg, euw_decode and assert_macros.svh.
`include "assert_macros.svh"

module encoded_word_unescaper #(
	parameter int DEPTH = 8 // result queue entries, power of two, at least 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       op,
	input  logic [7:0] byte_value,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_mark,
	output logic       last_of_run
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW:0] LIMIT = (CW + 1)'(DEPTH - 2);

	logic              valid_s1;
	logic              op_s1;
	logic [7:0]        byte_s1;
	euw_pkg::dec_out_t dec;

	euw_pkg::result_t  queue_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     fill_q;
	logic [CW:0]       reserve;
	logic              accept, pop;
	euw_pkg::result_t  head;

	// room for two results from this item plus two from the one in flight
	assign reserve    = {1'b0, fill_q} + (valid_s1 ? (CW + 1)'(2) : '0);
	assign item_stall = reserve > LIMIT;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			byte_s1 <= byte_value;
		end
	end

	euw_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (valid_s1),
		.op         (op_s1),
		.byte_value (byte_s1),
		.dec        (dec)
	);

	assign pop = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		if (valid_s1 && dec.count != 2'd0) begin
			queue_q[wr_ptr_q] <= dec.first;
		end
		if (valid_s1 && dec.count == 2'd2) begin
			queue_q[AW'(wr_ptr_q + AW'(1))] <= dec.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= AW'(wr_ptr_q + AW'(dec.count));
			end
			if (pop) begin
				rd_ptr_q <= AW'(rd_ptr_q + AW'(1));
			end
			fill_q <= CW'(fill_q + (valid_s1 ? CW'(dec.count) : CW'(0))
				- (pop ? CW'(1) : CW'(0)));
		end
	end

	assign head         = queue_q[rd_ptr_q];
	assign result_valid = fill_q != '0;
	assign out_byte     = head.out_byte;
	assign byte_valid   = head.byte_valid;
	assign end_mark     = head.end_mark;
	assign last_of_run  = head.last_of_run;

	`CHK_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= CW'(DEPTH), "queue fill beyond depth")
	`CHK_IMPLY(a_no_overflow, clk, arst_n, valid_s1, ({1'b0, fill_q} + (CW + 1)'(dec.count)) <= (CW + 1)'(DEPTH), "queue push would overflow")
	`CHK_IMPLY(a_end_shape, clk, arst_n, result_valid && end_mark, last_of_run && !byte_valid && out_byte == 8'd0, "end mark result malformed")

endmodule
